@@ design/aff2i_pkg.sv @@
// Package with the shared widths, payload types and pipeline constants of the affine inverse.
package aff2i_pkg;

  localparam int unsigned Word = 32;
  localparam int unsigned ProdW = 2 * Word;
  localparam int unsigned RemW = ProdW - 1;
  localparam int unsigned WideW = 2 * ProdW;
  localparam int unsigned NumLanes = 6;
  localparam int unsigned DivStepsPerStage = 2;
  localparam int unsigned DivStages = Word / DivStepsPerStage;
  localparam int unsigned FracBitsDefault = 16;

  typedef struct packed {
    logic signed [Word-1:0] m00;
    logic signed [Word-1:0] m01;
    logic signed [Word-1:0] m10;
    logic signed [Word-1:0] m11;
    logic signed [Word-1:0] trans_x;
    logic signed [Word-1:0] trans_y;
  } mat_t;

  typedef struct packed {
    logic signed [Word-1:0]  m00;
    logic signed [Word-1:0]  m01;
    logic signed [Word-1:0]  m10;
    logic signed [Word-1:0]  m11;
    logic signed [ProdW-1:0] det;
    logic signed [ProdW-1:0] ntx;
    logic signed [ProdW-1:0] nty;
  } num_t;

  typedef struct packed {
    logic [NumLanes-1:0][RemW-1:0] rem;
    logic [NumLanes-1:0][Word-1:0] low;
    logic [NumLanes-1:0][Word-1:0] quo;
    logic [NumLanes-1:0]           neg;
    logic [NumLanes-1:0]           big;
    logic [RemW-1:0]               dmag;
    logic                          singular;
  } div_t;

  typedef struct packed {
    logic signed [Word-1:0] inv00;
    logic signed [Word-1:0] inv01;
    logic signed [Word-1:0] inv10;
    logic signed [Word-1:0] inv11;
    logic signed [Word-1:0] inv_trans_x;
    logic signed [Word-1:0] inv_trans_y;
    logic                   singular;
    logic                   saturated;
  } res_t;

endpackage

@@ design/aff2i_if.sv @@
// Valid/ready channel interfaces for the matrix input and the inverse output.
interface aff2i_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  modport source(output valid, m00, m01, m10, m11, trans_x, trans_y, input ready);
  modport sink(input valid, m00, m01, m10, m11, trans_x, trans_y, output ready);
endinterface

interface aff2i_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] inv00;
  logic signed [31:0] inv01;
  logic signed [31:0] inv10;
  logic signed [31:0] inv11;
  logic signed [31:0] inv_trans_x;
  logic signed [31:0] inv_trans_y;
  logic singular;
  logic saturated;
  modport source(output valid, inv00, inv01, inv10, inv11, inv_trans_x, inv_trans_y,
                 singular, saturated, input ready);
  modport sink(input valid, inv00, inv01, inv10, inv11, inv_trans_x, inv_trans_y,
               singular, saturated, output ready);
endinterface

@@ design/aff2i_front.sv @@
// Two pipeline stages: the six cross products, then the determinant and translation numerators.
module aff2i_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aff2i_pkg::mat_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aff2i_pkg::num_t    data_o
);
  import aff2i_pkg::*;

  logic                    p_valid_q;
  logic                    p_ready;
  logic signed [ProdW-1:0] p_ae_q, p_bc_q, p_cty_q, p_etx_q, p_btx_q, p_aty_q;
  logic signed [Word-1:0]  p_a_q, p_b_q, p_c_q, p_e_q;
  logic                    n_valid_q;
  num_t                    n_data_d, n_data_q;

  assign p_ready = !n_valid_q || ready_i;
  assign ready_o = !p_valid_q || p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      n_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        p_valid_q <= valid_i;
      end
      if (p_ready) begin
        n_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_ae_q  <= ProdW'(data_i.m00) * ProdW'(data_i.m11);
      p_bc_q  <= ProdW'(data_i.m01) * ProdW'(data_i.m10);
      p_cty_q <= ProdW'(data_i.m10) * ProdW'(data_i.trans_y);
      p_etx_q <= ProdW'(data_i.m11) * ProdW'(data_i.trans_x);
      p_btx_q <= ProdW'(data_i.m01) * ProdW'(data_i.trans_x);
      p_aty_q <= ProdW'(data_i.m00) * ProdW'(data_i.trans_y);
      p_a_q   <= data_i.m00;
      p_b_q   <= data_i.m01;
      p_c_q   <= data_i.m10;
      p_e_q   <= data_i.m11;
    end
  end

  always_comb begin
    n_data_d.m00 = p_a_q;
    n_data_d.m01 = p_b_q;
    n_data_d.m10 = p_c_q;
    n_data_d.m11 = p_e_q;
    n_data_d.det = p_ae_q - p_bc_q;
    n_data_d.ntx = p_cty_q - p_etx_q;
    n_data_d.nty = p_btx_q - p_aty_q;
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && p_valid_q) begin
      n_data_q <= n_data_d;
    end
  end

  assign valid_o = n_valid_q;
  assign data_o  = n_data_q;

endmodule

@@ design/aff2i_prep.sv @@
// Divider setup stage: magnitudes, quotient signs, scaled dividends and the overflow precheck.
module aff2i_prep #(
  parameter int unsigned FRAC_BITS = aff2i_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aff2i_pkg::num_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aff2i_pkg::div_t    data_o
);
  import aff2i_pkg::*;

  logic                    valid_q;
  div_t                    data_d, data_q;
  logic signed [ProdW-1:0] num [NumLanes];
  logic [ProdW-1:0]        dabs;

  always_comb begin
    logic [ProdW-1:0] nabs;
    logic [WideW-1:0] wide;
    num[0] = ProdW'(data_i.m11);
    num[1] = -ProdW'(data_i.m01);
    num[2] = -ProdW'(data_i.m10);
    num[3] = ProdW'(data_i.m00);
    num[4] = data_i.ntx;
    num[5] = data_i.nty;
    dabs = data_i.det[ProdW-1] ? -data_i.det : data_i.det;
    data_d.dmag = dabs[RemW-1:0];
    data_d.singular = (data_i.det == '0);
    for (int l = 0; l < NumLanes; l++) begin
      nabs = num[l][ProdW-1] ? -num[l] : num[l];
      if (l < 4) begin
        wide = {{(WideW-ProdW){1'b0}}, nabs} << (2 * FRAC_BITS);
      end else begin
        wide = {{(WideW-ProdW){1'b0}}, nabs} << FRAC_BITS;
      end
      data_d.neg[l] = num[l][ProdW-1] ^ data_i.det[ProdW-1];
      data_d.big[l] = wide[WideW-1:Word] >= {{(WideW-Word-RemW){1'b0}}, dabs[RemW-1:0]};
      data_d.rem[l] = data_d.big[l] ? '0 : wide[Word+RemW-1:Word];
      data_d.low[l] = wide[Word-1:0];
      data_d.quo[l] = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/aff2i_div_stage.sv @@
// One divider stage: DivStepsPerStage restoring division steps on all six lanes.
module aff2i_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aff2i_pkg::div_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aff2i_pkg::div_t    data_o
);
  import aff2i_pkg::*;

  logic valid_q;
  div_t data_d, data_q;

  always_comb begin
    logic [RemW:0] trial;
    logic          qbit;
    data_d = data_i;
    for (int l = 0; l < NumLanes; l++) begin
      for (int s = 0; s < DivStepsPerStage; s++) begin
        trial = {data_d.rem[l], data_d.low[l][Word-1]};
        qbit  = trial >= {1'b0, data_d.dmag};
        if (qbit) begin
          trial = trial - {1'b0, data_d.dmag};
        end
        data_d.rem[l] = trial[RemW-1:0];
        data_d.low[l] = {data_d.low[l][Word-2:0], 1'b0};
        data_d.quo[l] = {data_d.quo[l][Word-2:0], qbit};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/aff2i_out.sv @@
// Output stage: sign restore, saturation, singular override and the output register.
module aff2i_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aff2i_pkg::div_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aff2i_pkg::res_t    data_o
);
  import aff2i_pkg::*;

  logic                          valid_q;
  res_t                          data_d, data_q;
  logic [NumLanes-1:0][Word-1:0] elem;
  logic [NumLanes-1:0]           sat;

  always_comb begin
    logic [Word-1:0] q;
    for (int l = 0; l < NumLanes; l++) begin
      q = data_i.quo[l];
      if (data_i.neg[l]) begin
        sat[l] = data_i.big[l] || (q[Word-1] && (q[Word-2:0] != '0));
      end else begin
        sat[l] = data_i.big[l] || q[Word-1];
      end
      if (data_i.singular) begin
        elem[l] = '0;
      end else if (sat[l]) begin
        elem[l] = data_i.neg[l] ? {1'b1, {(Word-1){1'b0}}} : {1'b0, {(Word-1){1'b1}}};
      end else begin
        elem[l] = data_i.neg[l] ? -q : q;
      end
    end
    data_d.inv00       = elem[0];
    data_d.inv01       = elem[1];
    data_d.inv10       = elem[2];
    data_d.inv11       = elem[3];
    data_d.inv_trans_x = elem[4];
    data_d.inv_trans_y = elem[5];
    data_d.singular    = data_i.singular;
    data_d.saturated   = !data_i.singular && (sat != '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/affine_2d_inverse_unit.sv @@
// Top level of the 2D affine matrix inverse pipeline.
// The unit inverts one 2D affine matrix (2x2 linear part plus translation row, signed
// Q16.16) per clock cycle while the output is not stalled, and returns the six inverse
// elements truncated toward zero and saturated to Q16.16, with singular and saturated
// flags. Every transaction passes from input to output register through one multiplier
// stage, one determinant stage, one divider setup stage, sixteen stages of the exact
// restoring divider (two quotient bits each across six parallel lanes), and one saturation
// stage. Each stage has its own valid bit and stalls only while its successor is full, so
// bubbles close up under backpressure; unstalled, throughput is one transaction per cycle.
module affine_2d_inverse_unit #(
  parameter int unsigned FRAC_BITS = aff2i_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aff2i_in_if.sink    in_i,
  aff2i_out_if.source out_o
);
  import aff2i_pkg::*;

  mat_t                 mat;
  logic                 f_valid, f_ready;
  num_t                 f_data;
  logic [DivStages:0]   d_valid, d_ready;
  div_t                 d_data [DivStages+1];
  logic                 o_ready;
  res_t                 res;

  assign mat.m00     = in_i.m00;
  assign mat.m01     = in_i.m01;
  assign mat.m10     = in_i.m10;
  assign mat.m11     = in_i.m11;
  assign mat.trans_x = in_i.trans_x;
  assign mat.trans_y = in_i.trans_y;

  aff2i_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (mat),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .data_o  (f_data)
  );

  aff2i_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .valid_o (d_valid[0]),
    .ready_i (d_ready[0]),
    .data_o  (d_data[0])
  );

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    aff2i_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_valid[g]),
      .ready_o (d_ready[g]),
      .data_i  (d_data[g]),
      .valid_o (d_valid[g+1]),
      .ready_i (d_ready[g+1]),
      .data_o  (d_data[g+1])
    );
  end

  assign d_ready[DivStages] = o_ready;

  aff2i_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid[DivStages]),
    .ready_o (o_ready),
    .data_i  (d_data[DivStages]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.inv00       = res.inv00;
  assign out_o.inv01       = res.inv01;
  assign out_o.inv10       = res.inv10;
  assign out_o.inv11       = res.inv11;
  assign out_o.inv_trans_x = res.inv_trans_x;
  assign out_o.inv_trans_y = res.inv_trans_y;
  assign out_o.singular    = res.singular;
  assign out_o.saturated   = res.saturated;

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |-> (res.inv00 == '0) && (res.inv11 == '0)
      && (res.inv01 == '0) && (res.inv10 == '0)
      && (res.inv_trans_x == '0) && (res.inv_trans_y == '0))
    else $error("singular result carries nonzero elements");

  a_singular_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.singular && out_o.saturated))
    else $error("singular and saturated flags both set");

  a_out_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid[DivStages] && o_ready |=> out_o.valid)
    else $error("divider transaction lost at the output stage");

  a_stall_holds_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !f_ready |=> f_valid && $stable(f_data))
    else $error("front stage changed while stalled");

endmodule

@@ bench/affine_2d_inverse_unit_test.sv @@
// Self-checking bench for the affine inverse unit: random and corner matrices against a predictor.
module affine_2d_inverse_unit_test;
  import aff2i_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned RandItems = 1130;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Latency = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aff2i_in_if in_ch ();
  aff2i_out_if out_ch ();

  affine_2d_inverse_unit #(.FRAC_BITS(FracBits)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  mat_t pending_mats[$];
  res_t expected_inverses[$];
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned singular_count = 0;
  int unsigned clamped_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned sink_gap = 0;
  bit stim_done = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact num * 2^sh / den truncated toward zero and clamped to 32 bits.
  function automatic logic [31:0] div_clamp(input logic signed [63:0] num, input int sh,
                                            input logic signed [63:0] den, inout bit sat);
    logic signed [127:0] wide_num;
    logic signed [127:0] quo;
    wide_num = 128'(num) <<< sh;
    quo = wide_num / 128'(den);
    if (quo > 128'sh7fffffff) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (quo < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return quo[31:0];
  endfunction

  function automatic res_t invert_matrix(input mat_t m);
    res_t r;
    logic signed [63:0] det, ntx, nty;
    bit sat;
    sat = 1'b0;
    r = '0;
    det = 64'(m.m00) * 64'(m.m11) - 64'(m.m01) * 64'(m.m10);
    ntx = 64'(m.m10) * 64'(m.trans_y) - 64'(m.m11) * 64'(m.trans_x);
    nty = 64'(m.m01) * 64'(m.trans_x) - 64'(m.m00) * 64'(m.trans_y);
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.inv00 = div_clamp(64'(m.m11), 2 * FracBits, det, sat);
    r.inv01 = div_clamp(-64'(m.m01), 2 * FracBits, det, sat);
    r.inv10 = div_clamp(-64'(m.m10), 2 * FracBits, det, sat);
    r.inv11 = div_clamp(64'(m.m00), 2 * FracBits, det, sat);
    r.inv_trans_x = div_clamp(ntx, FracBits, det, sat);
    r.inv_trans_y = div_clamp(nty, FracBits, det, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      5: return 32'($signed($urandom_range(0, 255)) - 128);
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_mat(input logic [31:0] a, b, c, d, tx, ty);
    mat_t m;
    m = '{a, b, c, d, tx, ty};
    pending_mats.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    error_count++;
    $display("mismatch on %s: got %h, expected %h", what, got, exp);
  endtask

  initial begin
    mat_t m;
    add_mat(32'h10000, 0, 0, 32'h10000, 0, 0);
    add_mat(32'h10000, 0, 0, 32'h10000, 32'h7fffffff, 32'h80000000);
    add_mat(0, 0, 0, 0, 32'h1234, 32'h5678);
    add_mat(32'h20000, 32'h40000, 32'h10000, 32'h20000, 1, 2);
    add_mat(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1);
    add_mat(32'h80000000, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    add_mat(32'h7fffffff, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_mat(1, 0, 0, 1, 32'h7fffffff, 32'h80000000);
    add_mat(0, 32'h10000, 32'hffff0000, 0, 32'h30000, 32'hfffd0000);
    add_mat(32'hffffffff, 32'h7fffffff, 32'h80000000, 1, 32'hffffffff, 32'hffffffff);
    add_mat(32'h8000, 32'h4000, 32'h2000, 32'h1000, 32'h10000, 32'h20000);
    add_mat(32'h10000, 32'h10000, 32'h10000, 32'h10000, 5, 7);
    add_mat(3, 5, 7, 11, 32'h55555555, 32'haaaaaaaa);
    for (int i = 0; i < RandItems; i++) begin
      m = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
      if ($urandom_range(0, 19) == 0) begin
        m.m10 = m.m00;
        m.m11 = m.m01;
      end
      pending_mats.push_back(m);
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.m00, in_ch.m01, in_ch.m10, in_ch.m11, in_ch.trans_x, in_ch.trans_y} <= '0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_mats.size() != 0) begin
      mat_t m;
      m = pending_mats.pop_front();
      expected_inverses.push_back(invert_matrix(m));
      in_ch.valid <= 1'b1;
      {in_ch.m00, in_ch.m01, in_ch.m10, in_ch.m11, in_ch.trans_x, in_ch.trans_y} <= m;
      sent_count <= sent_count + 1;
      send_gap <= pick_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t exp;
        checked_count <= checked_count + 1;
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          exp = expected_inverses.pop_front();
          if (exp.singular) singular_count++;
          if (exp.saturated) clamped_count++;
          if (out_ch.inv00 !== exp.inv00) report_mismatch("inv00", out_ch.inv00, exp.inv00);
          if (out_ch.inv01 !== exp.inv01) report_mismatch("inv01", out_ch.inv01, exp.inv01);
          if (out_ch.inv10 !== exp.inv10) report_mismatch("inv10", out_ch.inv10, exp.inv10);
          if (out_ch.inv11 !== exp.inv11) report_mismatch("inv11", out_ch.inv11, exp.inv11);
          if (out_ch.inv_trans_x !== exp.inv_trans_x)
            report_mismatch("inv_trans_x", out_ch.inv_trans_x, exp.inv_trans_x);
          if (out_ch.inv_trans_y !== exp.inv_trans_y)
            report_mismatch("inv_trans_y", out_ch.inv_trans_y, exp.inv_trans_y);
          if (out_ch.singular !== exp.singular)
            report_mismatch("singular", out_ch.singular, exp.singular);
          if (out_ch.saturated !== exp.saturated)
            report_mismatch("saturated", out_ch.saturated, exp.saturated);
        end
      end
      if (sink_gap != 0) begin
        out_ch.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni && stim_done);
    while (pending_mats.size() != 0 || in_ch.valid || expected_inverses.size() != 0) begin
      @(posedge clk_i);
      if (idle_cycles > IdleLimit) begin
        $display("timeout with %0d transactions outstanding", expected_inverses.size());
        $display("FAIL");
        $finish;
      end
    end
    repeat (4 * Latency) @(posedge clk_i);
    $display("Inverted %0d matrices and checked %0d transactions,", sent_count, checked_count);
    $display("%0d singular and %0d clamped; %0d mismatches.", singular_count, clamped_count,
             error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
